@@ src/rrf_pkg.sv @@
// Shared types and constants for the radio range fan-out block.
`timescale 1ns / 1ps
package rrf_pkg;

	localparam int COORD_W = 32;
	localparam int RANGE_W = 31;
	localparam int NODE_W  = 4;
	localparam int REACH_W = 2;

	localparam logic [RANGE_W-1:0] DATA_RAD_RST  = 31'd20000000;
	localparam logic [RANGE_W-1:0] SENSE_RAD_RST = 31'd40000000;

	localparam logic REG_DATA_RAD  = 1'b0;
	localparam logic REG_SENSE_RAD = 1'b1;

	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_WRITE  = 1'b1;

	localparam logic [REACH_W-1:0] REACH_NONE  = 2'd0;
	localparam logic [REACH_W-1:0] REACH_DATA  = 2'd1;
	localparam logic [REACH_W-1:0] REACH_SENSE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TX,
		ST_CS,
		ST_CSW,
		ST_LD,
		ST_SQX,
		ST_SQY,
		ST_EMIT
	} rrf_state_t;

endpackage

@@ src/rrf_pos_store.sv @@
// Node position store with per-entry valid bits and registered read.
`timescale 1ns / 1ps
module rrf_pos_store
	import rrf_pkg::*;
#(
	parameter int NODES = 16,
	parameter int AW    = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic signed [COORD_W-1:0] wr_x,
	input  logic signed [COORD_W-1:0] wr_y,
	input  logic [AW-1:0]             rd_addr,
	output logic signed [COORD_W-1:0] rd_x,
	output logic signed [COORD_W-1:0] rd_y
);

	logic signed [COORD_W-1:0] mem_x_q [NODES];
	logic signed [COORD_W-1:0] mem_y_q [NODES];
	logic [NODES-1:0]          vld_q;
	logic signed [COORD_W-1:0] rd_x_q;
	logic signed [COORD_W-1:0] rd_y_q;
	logic                      rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x_q[wr_addr] <= wr_x;
			mem_y_q[wr_addr] <= wr_y;
		end
	end

	always_ff @(posedge clk) begin
		rd_x_q <= mem_x_q[rd_addr];
		rd_y_q <= mem_y_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_x = rd_vld_q ? rd_x_q : '0;
	assign rd_y = rd_vld_q ? rd_y_q : '0;

endmodule

@@ src/radio_range_fanout_top.sv @@
// Top level: position table, range registers and the shared squaring sequencer.
//
//  Channel  Direction  Handshake                 Payload
//  in       sink       in_valid / in_stall       func, node_index, pos_x, pos_y
//  out      source     out_valid / out_stall     dest_node, reach, last
//  cfg      sink       APB psel/penable/pwrite   paddr, pwdata, prdata
//
//  A packet first reads the source position and squares the two ranges (setup), then loads,
//  squares dx, squares dy and emits a beat for each other node, all through the single 33x33
//  squaring multiplier that serves ranges, dx and dy in turn.
//  A stalled output beat holds the sequencer in its emit step until the beat is taken.
//  Reset clears the position valid bits, so every node reads at the origin until written.
`timescale 1ns / 1ps
module radio_range_fanout_top
	import rrf_pkg::*;
#(
	parameter int NODES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [NODE_W-1:0]         node_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [NODE_W-1:0]         dest_node,
	output logic [REACH_W-1:0]        reach,
	output logic                      last,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int CW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [CW:0] NODES_C = (CW + 1)'(NODES);

	rrf_state_t state_q, state_d;

	logic [RANGE_W-1:0]        data_rad_q, sense_rad_q;
	logic [CW-1:0]             src_q, d_q;
	logic signed [COORD_W-1:0] src_x_q, src_y_q;
	logic [COORD_W:0]          dx_q, dy_q;
	logic [2*RANGE_W-1:0]      tx2_q, cs2_q;
	logic [2*COORD_W:0]        prod_q;
	logic [2*COORD_W+1:0]      sum_q;
	logic                      out_valid_q, last_q;
	logic [NODE_W-1:0]         dest_node_q;
	logic [REACH_W-1:0]        reach_q;

	logic                      in_acc, idx_ok, wr_en, cfg_wr;
	logic [CW-1:0]             rd_addr, first_d, nxt_d;
	logic [CW:0]               p1, p2;
	logic                      is_last, out_ld;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic [COORD_W:0]          mul_op;
	logic [2*COORD_W+1:0]      mul_res;
	logic [COORD_W:0]          ax, ay;
	logic [REACH_W-1:0]        reach_d;

	rrf_pos_store #(
		.NODES(NODES),
		.AW   (CW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(CW'(node_index)),
		.wr_x   (pos_x),
		.wr_y   (pos_y),
		.rd_addr(rd_addr),
		.rd_x   (rd_x),
		.rd_y   (rd_y)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = {1'b0, (paddr[2] == REG_SENSE_RAD) ? sense_rad_q : data_rad_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_rad_q  <= DATA_RAD_RST;
			sense_rad_q <= SENSE_RAD_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DATA_RAD) begin
				data_rad_q <= pwdata[RANGE_W-1:0];
			end else begin
				sense_rad_q <= pwdata[RANGE_W-1:0];
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign idx_ok   = (int'(node_index) < NODES);
	assign wr_en    = in_acc && (func == FUNC_WRITE) && idx_ok;

	assign first_d = (src_q == '0) ? CW'(1) : '0;
	assign p1      = {1'b0, d_q} + (CW + 1)'(1);
	assign p2      = p1 + (CW + 1)'(1);
	assign nxt_d   = (p1[CW-1:0] == src_q) ? p2[CW-1:0] : p1[CW-1:0];
	assign is_last = (p1 == NODES_C) || ((p1[CW-1:0] == src_q) && (p2 == NODES_C));
	assign out_ld  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign ax = ($signed({rd_x[COORD_W-1], rd_x}) >= $signed({src_x_q[COORD_W-1], src_x_q}))
		? ({rd_x[COORD_W-1], rd_x} - {src_x_q[COORD_W-1], src_x_q})
		: ({src_x_q[COORD_W-1], src_x_q} - {rd_x[COORD_W-1], rd_x});
	assign ay = ($signed({rd_y[COORD_W-1], rd_y}) >= $signed({src_y_q[COORD_W-1], src_y_q}))
		? ({rd_y[COORD_W-1], rd_y} - {src_y_q[COORD_W-1], src_y_q})
		: ({src_y_q[COORD_W-1], src_y_q} - {rd_y[COORD_W-1], rd_y});

	assign mul_res = {1'b0, mul_op} * {1'b0, mul_op};

	always_comb begin
		if (sum_q < {4'b0, tx2_q}) begin
			reach_d = REACH_DATA;
		end else if (sum_q < {4'b0, cs2_q}) begin
			reach_d = REACH_SENSE;
		end else begin
			reach_d = REACH_NONE;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = d_q;
		mul_op  = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = CW'(node_index);
				if (in_acc && (func == FUNC_PACKET) && idx_ok) begin
					state_d = ST_TX;
				end
			end
			ST_TX: begin
				mul_op  = {2'b0, data_rad_q};
				state_d = ST_CS;
			end
			ST_CS: begin
				mul_op  = {2'b0, sense_rad_q};
				state_d = ST_CSW;
			end
			ST_CSW: begin
				rd_addr = first_d;
				state_d = ST_LD;
			end
			ST_LD: begin
				state_d = ST_SQX;
			end
			ST_SQX: begin
				mul_op  = dx_q;
				state_d = ST_SQY;
			end
			ST_SQY: begin
				mul_op  = dy_q;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				rd_addr = nxt_d;
				if (out_ld) begin
					state_d = is_last ? ST_IDLE : ST_LD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_res[2*COORD_W:0];
		if (in_acc) begin
			src_q <= CW'(node_index);
		end
		case (state_q)
			ST_TX: begin
				src_x_q <= rd_x;
				src_y_q <= rd_y;
			end
			ST_CS: begin
				tx2_q <= prod_q[2*RANGE_W-1:0];
			end
			ST_CSW: begin
				cs2_q <= prod_q[2*RANGE_W-1:0];
				d_q   <= first_d;
			end
			ST_LD: begin
				dx_q <= ax;
				dy_q <= ay;
			end
			ST_SQY: begin
				sum_q <= {1'b0, prod_q} + mul_res;
			end
			ST_EMIT: begin
				if (out_ld) begin
					d_q <= nxt_d;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			dest_node_q <= NODE_W'(d_q);
			reach_q     <= reach_d;
			last_q      <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign dest_node = dest_node_q;
	assign reach     = reach_q;
	assign last      = last_q;

	a_skip_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD || state_q == ST_SQX || state_q == ST_SQY || state_q == ST_EMIT)
		|-> (d_q != src_q))
		else $error("walk reached the sending node");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD || state_q == ST_EMIT) |-> (int'(d_q) < NODES))
		else $error("walk index beyond the node table");

	a_beat_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result beat raised outside the emit step");

	a_reach_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (reach == REACH_NONE || reach == REACH_DATA || reach == REACH_SENSE))
		else $error("undefined reach code on output");

endmodule
